/* sv/rvnd_pkg.sv */
// Package: shared types and constants for the RTP VVC NAL depacketizer.
package rvnd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [4:0] TypeAp   = 5'd28;
  localparam logic [4:0] TypeFu   = 5'd29;
  localparam logic [7:0] TypeMask = 8'h1f;
  localparam logic [7:0] TidMask  = 8'h07;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_AP     = 2'd2,
    KIND_FU     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FRAG_IDLE    = 2'd0,
    FRAG_COLLECT = 2'd1,
    FRAG_LOST    = 2'd2
  } frag_e;

  typedef enum logic [1:0] {
    AGG_LEN_HI = 2'd0,
    AGG_LEN_LO = 2'd1,
    AGG_DATA   = 2'd2
  } agg_e;

  typedef enum logic [2:0] {
    SL_PRE  = 3'd0,
    SL_SC0  = 3'd1,
    SL_SC1  = 3'd2,
    SL_SC2  = 3'd3,
    SL_SC3  = 3'd4,
    SL_D0   = 3'd5,
    SL_D1   = 3'd6,
    SL_POST = 3'd7
  } slot_e;

  localparam int unsigned NumSlots = 8;

  typedef struct packed {
    logic        pre_abort;
    logic        open;
    logic [31:0] stamp;
    logic        d0_valid;
    logic [7:0]  d0;
    logic        d0_last;
    logic        d1_valid;
    logic [7:0]  d1;
    logic        d1_last;
    logic        post_abort;
  } cmd_t;

endpackage

/* sv/rvnd_if.sv */
// Interfaces: input payload word channel and output NAL word channel.
interface rvnd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_first;
  logic        byte_last;
  logic [15:0] payload_len;
  logic [15:0] seq_num;
  logic        marker;
  logic [31:0] stamp_ms;
  modport source (output valid, payload_byte, byte_first, byte_last, payload_len,
                  seq_num, marker, stamp_ms, input ready);
  modport sink (input valid, payload_byte, byte_first, byte_last, payload_len,
                seq_num, marker, stamp_ms, output ready);
endinterface

interface rvnd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        nal_first;
  logic        nal_last;
  logic        nal_abort;
  logic [31:0] nal_stamp;
  logic        run_last;
  modport source (output valid, out_byte, nal_first, nal_last, nal_abort, nal_stamp,
                  run_last, input ready);
  modport sink (input valid, out_byte, nal_first, nal_last, nal_abort, nal_stamp,
                run_last, output ready);
endinterface

/* sv/rvnd_front.sv */
// Front: packet parser that turns each payload word into at most one output command.
module rvnd_front import rvnd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvnd_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [15:0] byte_pos_q, byte_pos_d;
  kind_e       pkt_kind_q, pkt_kind_d;
  logic [7:0]  hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  frag_e       frag_q, frag_d;
  logic [15:0] prev_seq_q, prev_seq_d;
  logic        first_pkt_q, first_pkt_d;
  logic [15:0] agg_rem_q, agg_rem_d;
  agg_e        agg_q, agg_d;
  logic [7:0]  len_high_q, len_high_d;
  logic        drop_q, drop_d;
  logic        end_pend_q, end_pend_d;
  logic        in_pkt_q, in_pkt_d;
  logic        nal_open_q, nal_open_d;
  logic        gap_q, gap_d;
  logic [15:0] pkt_len_q, pkt_len_d;
  logic        pkt_marker_q, pkt_marker_d;
  logic [31:0] pkt_stamp_q, pkt_stamp_d;
  logic [7:0]  held_q, held_d;
  logic        held_v_q, held_v_d;

  logic        accept;
  cmd_t        cmd;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] p;
    logic [4:0]  ntype;
    logic [15:0] fs;
    logic        go;
    b            = in_i.payload_byte;
    byte_pos_d   = byte_pos_q;
    pkt_kind_d   = pkt_kind_q;
    hdr0_d       = hdr0_q;
    hdr1_d       = hdr1_q;
    frag_d       = frag_q;
    prev_seq_d   = prev_seq_q;
    first_pkt_d  = first_pkt_q;
    agg_rem_d    = agg_rem_q;
    agg_d        = agg_q;
    len_high_d   = len_high_q;
    drop_d       = drop_q;
    end_pend_d   = end_pend_q;
    in_pkt_d     = in_pkt_q;
    nal_open_d   = nal_open_q;
    gap_d        = gap_q;
    pkt_len_d    = pkt_len_q;
    pkt_marker_d = pkt_marker_q;
    pkt_stamp_d  = pkt_stamp_q;
    held_d       = held_q;
    held_v_d     = held_v_q;
    cmd          = '0;
    p            = byte_pos_q;
    ntype        = b[7:3];
    fs           = {len_high_q, b};
    go           = 1'b1;

    if (in_i.byte_first) begin
      if (in_pkt_q && nal_open_q) begin
        cmd.pre_abort = 1'b1;
        nal_open_d    = 1'b0;
        held_v_d      = 1'b0;
        frag_d        = FRAG_IDLE;
      end
      in_pkt_d     = 1'b1;
      p            = '0;
      pkt_kind_d   = KIND_NONE;
      drop_d       = 1'b0;
      agg_d        = AGG_LEN_HI;
      pkt_len_d    = in_i.payload_len;
      pkt_marker_d = in_i.marker;
      pkt_stamp_d  = in_i.stamp_ms;
      if (first_pkt_q) begin
        gap_d       = 1'b0;
        first_pkt_d = 1'b0;
      end else begin
        gap_d = in_i.seq_num != prev_seq_q + 16'd1;
      end
      prev_seq_d = in_i.seq_num;
    end else if (!in_pkt_q) begin
      go = 1'b0;
    end
    cmd.stamp = pkt_stamp_d;

    if (go) begin
      if (p == 16'd0) begin
        hdr0_d = b;
      end else if (p == 16'd1) begin
        hdr1_d = b;
        if (ntype < TypeAp) begin
          pkt_kind_d    = KIND_SINGLE;
          cmd.pre_abort = nal_open_d;
          held_v_d      = 1'b0;
          frag_d        = FRAG_IDLE;
          cmd.open      = 1'b1;
          cmd.d0_valid  = 1'b1;
          cmd.d0        = hdr0_q;
          cmd.d1_valid  = 1'b1;
          cmd.d1        = b;
          cmd.d1_last   = in_i.byte_last;
          nal_open_d    = !in_i.byte_last;
        end else if (ntype == TypeAp) begin
          pkt_kind_d    = KIND_AP;
          cmd.pre_abort = nal_open_d;
          nal_open_d    = 1'b0;
          held_v_d      = 1'b0;
          frag_d        = FRAG_IDLE;
          agg_d         = AGG_LEN_HI;
        end else if (ntype == TypeFu) begin
          pkt_kind_d = KIND_FU;
        end else begin
          pkt_kind_d = KIND_NONE;
        end
      end else if (pkt_kind_q == KIND_SINGLE) begin
        cmd.d0_valid = 1'b1;
        cmd.d0       = b;
        cmd.d0_last  = in_i.byte_last;
        if (in_i.byte_last) nal_open_d = 1'b0;
      end else if (pkt_kind_q == KIND_AP) begin
        if (!drop_q) begin
          unique case (agg_q)
            AGG_LEN_HI: begin
              if ({1'b0, pkt_len_q} > {1'b0, p} + 17'd2) begin
                len_high_d = b;
                agg_d      = AGG_LEN_LO;
              end else begin
                drop_d = 1'b1;
              end
            end
            AGG_LEN_LO: begin
              if (fs == 16'd0 ||
                  {2'b0, pkt_len_q} < {2'b0, p} + 18'd1 + {2'b0, fs}) begin
                drop_d = 1'b1;
              end else begin
                agg_rem_d  = fs;
                agg_d      = AGG_DATA;
                cmd.open   = 1'b1;
                nal_open_d = 1'b1;
              end
            end
            default: begin
              agg_rem_d    = agg_rem_q - 16'd1;
              cmd.d0_valid = 1'b1;
              cmd.d0       = b;
              cmd.d0_last  = agg_rem_d == 16'd0;
              if (agg_rem_d == 16'd0) begin
                nal_open_d = 1'b0;
                agg_d      = AGG_LEN_HI;
              end
            end
          endcase
        end
      end else if (pkt_kind_q == KIND_FU) begin
        if (p == 16'd2) begin
          if (b[7]) begin
            cmd.pre_abort = nal_open_d;
            frag_d        = FRAG_COLLECT;
            cmd.open      = 1'b1;
            nal_open_d    = 1'b1;
            cmd.d0_valid  = 1'b1;
            cmd.d0        = hdr0_q;
            held_d        = ((b & TypeMask) << 3) | (hdr1_q & TidMask);
            held_v_d      = 1'b1;
            end_pend_d    = b[6] || pkt_marker_q;
          end else if (frag_q != FRAG_COLLECT) begin
            drop_d = 1'b1;
          end else if (gap_q) begin
            cmd.pre_abort = nal_open_d;
            nal_open_d    = 1'b0;
            held_v_d      = 1'b0;
            frag_d        = FRAG_LOST;
            drop_d        = 1'b1;
          end else begin
            end_pend_d = b[6];
          end
        end else if (!drop_q && frag_q == FRAG_COLLECT) begin
          cmd.d0_valid = held_v_q;
          cmd.d0       = held_q;
          held_d       = b;
          held_v_d     = 1'b1;
        end
      end

      if (in_i.byte_last) begin
        if (pkt_kind_d == KIND_FU) begin
          if (p >= 16'd2 && !drop_d && frag_d == FRAG_COLLECT && end_pend_d) begin
            if (held_v_d) begin
              if (!cmd.d0_valid) begin
                cmd.d0_valid = 1'b1;
                cmd.d0       = held_d;
                cmd.d0_last  = 1'b1;
              end else begin
                cmd.d1_valid = 1'b1;
                cmd.d1       = held_d;
                cmd.d1_last  = 1'b1;
              end
            end
            held_v_d   = 1'b0;
            nal_open_d = 1'b0;
            frag_d     = FRAG_IDLE;
          end
        end else if (pkt_kind_d == KIND_SINGLE || pkt_kind_d == KIND_AP) begin
          if (nal_open_d) begin
            cmd.post_abort = 1'b1;
            nal_open_d     = 1'b0;
            held_v_d       = 1'b0;
            frag_d         = FRAG_IDLE;
          end
          agg_d = AGG_LEN_HI;
        end
        in_pkt_d = 1'b0;
      end
      byte_pos_d = (p != 16'hffff) ? p + 16'd1 : p;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.pre_abort || cmd.open || cmd.d0_valid ||
                             cmd.d1_valid || cmd.post_abort);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      pkt_kind_q   <= KIND_NONE;
      hdr0_q       <= '0;
      hdr1_q       <= '0;
      frag_q       <= FRAG_IDLE;
      prev_seq_q   <= '0;
      first_pkt_q  <= 1'b1;
      agg_rem_q    <= '0;
      agg_q        <= AGG_LEN_HI;
      len_high_q   <= '0;
      drop_q       <= 1'b0;
      end_pend_q   <= 1'b0;
      in_pkt_q     <= 1'b0;
      nal_open_q   <= 1'b0;
      gap_q        <= 1'b0;
      pkt_len_q    <= '0;
      pkt_marker_q <= 1'b0;
      pkt_stamp_q  <= '0;
      held_q       <= '0;
      held_v_q     <= 1'b0;
    end else if (accept) begin
      byte_pos_q   <= byte_pos_d;
      pkt_kind_q   <= pkt_kind_d;
      hdr0_q       <= hdr0_d;
      hdr1_q       <= hdr1_d;
      frag_q       <= frag_d;
      prev_seq_q   <= prev_seq_d;
      first_pkt_q  <= first_pkt_d;
      agg_rem_q    <= agg_rem_d;
      agg_q        <= agg_d;
      len_high_q   <= len_high_d;
      drop_q       <= drop_d;
      end_pend_q   <= end_pend_d;
      in_pkt_q     <= in_pkt_d;
      nal_open_q   <= nal_open_d;
      gap_q        <= gap_d;
      pkt_len_q    <= pkt_len_d;
      pkt_marker_q <= pkt_marker_d;
      pkt_stamp_q  <= pkt_stamp_d;
      held_q       <= held_d;
      held_v_q     <= held_v_d;
    end
  end

endmodule

/* sv/rvnd_queue.sv */
// Command queue between the parser and the output sequencer.
module rvnd_queue import rvnd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* sv/rvnd_back.sv */
// Back: expands each command into output words, one per cycle while the output is ready.
module rvnd_back import rvnd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  rvnd_out_if.source out_o
);

  logic [NumSlots-1:0] mask;
  logic [2:0]          slot_q, slot_d, cur;
  logic                has_more;
  logic                emit;
  logic [31:0]         latch_q;
  logic [7:0]          byte_n;
  logic                first_n, last_n, abort_n;

  logic        vld_q;
  logic [7:0]  byte_q;
  logic        first_q, last_q, abort_q, run_q;
  logic [31:0] stamp_q;

  assign mask = {head_i.post_abort, head_i.d1_valid, head_i.d0_valid,
                 {4{head_i.open}}, head_i.pre_abort};

  always_comb begin
    logic found;
    found    = 1'b0;
    cur      = slot_q;
    has_more = 1'b0;
    slot_d   = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (3'(i) >= slot_q && mask[i]) begin
        if (!found) begin
          cur   = 3'(i);
          found = 1'b1;
        end else if (!has_more) begin
          has_more = 1'b1;
          slot_d   = 3'(i);
        end
      end
    end
  end

  always_comb begin
    byte_n  = 8'h00;
    first_n = 1'b0;
    last_n  = 1'b0;
    abort_n = 1'b0;
    unique case (slot_e'(cur))
      SL_PRE, SL_POST: abort_n = 1'b1;
      SL_SC0: first_n = 1'b1;
      SL_SC1, SL_SC2: byte_n = 8'h00;
      SL_SC3: byte_n = 8'h01;
      SL_D0: begin
        byte_n = head_i.d0;
        last_n = head_i.d0_last;
      end
      SL_D1: begin
        byte_n = head_i.d1;
        last_n = head_i.d1_last;
      end
      default: byte_n = 8'h00;
    endcase
  end

  assign emit  = !empty_i && (!vld_q || out_o.ready);
  assign pop_o = emit && !has_more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      slot_q  <= '0;
      latch_q <= '0;
    end else begin
      if (emit) begin
        vld_q  <= 1'b1;
        slot_q <= has_more ? slot_d : 3'(SL_PRE);
        if (slot_e'(cur) == SL_SC0) latch_q <= head_i.stamp;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= byte_n;
      first_q <= first_n;
      last_q  <= last_n;
      abort_q <= abort_n;
      run_q   <= !has_more;
      stamp_q <= (slot_e'(cur) == SL_SC0) ? head_i.stamp : latch_q;
    end
  end

  assign out_o.valid     = vld_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.nal_first = first_q;
  assign out_o.nal_last  = last_q;
  assign out_o.nal_abort = abort_q;
  assign out_o.nal_stamp = stamp_q;
  assign out_o.run_last  = run_q;

endmodule

/* sv/rtp_vvc_nal_depacketizer.sv */
// Top level: RTP VVC payload to Annex-B NAL word stream.
// Accepts one payload word per cycle while the command queue has room.
// Each word yields zero to seven output words, delivered by the output sequencer
// one per cycle while the sink is ready, through the queue and output register.
// Sustained rate is bounded by output words: start-code bursts fill the queue.
// Asynchronous active-low reset clears parser state, queue pointers and output valid.
module rtp_vvc_nal_depacketizer import rvnd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvnd_in_if.sink    in_i,
  rvnd_out_if.source out_o
);

  logic push, full, pop, empty;
  cmd_t cmd, head;

  rvnd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  rvnd_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  rvnd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* test/rtp_vvc_nal_depacketizer_tb.sv */
// Testbench: drives RTP VVC payload words and checks the Annex-B NAL word stream.
module rtp_vvc_nal_depacketizer_tb;
  import rvnd_pkg::*;

  typedef struct packed {
    logic [7:0]  b;
    logic        first;
    logic        last;
    logic [15:0] len;
    logic [15:0] seq;
    logic        marker;
    logic [31:0] stamp;
  } pay_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        first;
    logic        last;
    logic        abort;
    logic [31:0] stamp;
    logic        run_last;
  } nal_word_t;

  class nal_scoreboard;
    nal_word_t   nal_q[$];
    int          errors;
    int          words_in;
    int          words_out;
    int          aborts_seen;
    logic [15:0] byte_pos;
    kind_e       kind;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    frag_e       frag;
    logic [15:0] prev_seq;
    logic        first_pkt;
    logic [15:0] agg_left;
    agg_e        agg;
    logic [7:0]  len_hi;
    logic        drop;
    logic        end_pend;
    logic [31:0] stamp_latch;
    logic        in_pkt;
    logic        nal_open;
    logic        seq_gap;
    logic [15:0] pkt_len;
    logic        pkt_marker;
    logic [31:0] pkt_stamp;
    logic [7:0]  held;
    logic        held_ok;
    int          n_new;

    function new();
      errors = 0;
      words_in = 0;
      words_out = 0;
      aborts_seen = 0;
      byte_pos = 0;
      kind = KIND_NONE;
      hdr0 = 0;
      hdr1 = 0;
      frag = FRAG_IDLE;
      prev_seq = 0;
      first_pkt = 1;
      agg_left = 0;
      agg = AGG_LEN_HI;
      len_hi = 0;
      drop = 0;
      end_pend = 0;
      stamp_latch = 0;
      in_pkt = 0;
      nal_open = 0;
      seq_gap = 0;
      pkt_len = 0;
      pkt_marker = 0;
      pkt_stamp = 0;
      held = 0;
      held_ok = 0;
    endfunction

    function void emit(logic [7:0] b, logic f, logic l, logic a);
      nal_word_t w;
      w.b = b;
      w.first = f;
      w.last = l;
      w.abort = a;
      w.stamp = stamp_latch;
      w.run_last = 0;
      nal_q = {nal_q, w};
      n_new++;
    endfunction

    function void kill_nal();
      if (nal_open) emit(8'h00, 0, 0, 1);
      nal_open = 0;
      held_ok = 0;
      frag = FRAG_IDLE;
    endfunction

    function void open_nal();
      stamp_latch = pkt_stamp;
      emit(8'h00, 1, 0, 0);
      emit(8'h00, 0, 0, 0);
      emit(8'h00, 0, 0, 0);
      emit(8'h01, 0, 0, 0);
      nal_open = 1;
    endfunction

    function void agg_step(logic [7:0] b, logic [31:0] p);
      logic [31:0] sz;
      if (agg == AGG_LEN_HI) begin
        if (32'(pkt_len) > p + 2) begin
          len_hi = b;
          agg = AGG_LEN_LO;
        end else drop = 1;
      end else if (agg == AGG_LEN_LO) begin
        sz = {16'h0, len_hi, b};
        if (sz == 0 || 32'(pkt_len) < p + 1 + sz) drop = 1;
        else begin
          agg_left = sz[15:0];
          agg = AGG_DATA;
          open_nal();
        end
      end else begin
        agg_left--;
        emit(b, 0, agg_left == 0, 0);
        if (agg_left == 0) begin
          nal_open = 0;
          agg = AGG_LEN_HI;
        end
      end
    endfunction

    function void frag_step(logic [7:0] b, logic [31:0] p);
      if (p == 2) begin
        if (b[7]) begin
          kill_nal();
          frag = FRAG_COLLECT;
          open_nal();
          emit(hdr0, 0, 0, 0);
          held = {b[4:0], hdr1[2:0]};
          held_ok = 1;
          end_pend = b[6] | pkt_marker;
        end else if (frag != FRAG_COLLECT) drop = 1;
        else if (seq_gap) begin
          kill_nal();
          frag = FRAG_LOST;
          drop = 1;
        end else end_pend = b[6];
      end else if (!drop && frag == FRAG_COLLECT) begin
        if (held_ok) emit(held, 0, 0, 0);
        held = b;
        held_ok = 1;
      end
    endfunction

    function void note_input(pay_word_t w);
      logic [31:0] p;
      logic [4:0]  typ;
      words_in++;
      n_new = 0;
      if (w.first) begin
        if (in_pkt && nal_open) kill_nal();
        in_pkt = 1;
        byte_pos = 0;
        kind = KIND_NONE;
        drop = 0;
        agg = AGG_LEN_HI;
        pkt_len = w.len;
        pkt_marker = w.marker;
        pkt_stamp = w.stamp;
        if (first_pkt) begin
          prev_seq = w.seq - 16'd1;
          first_pkt = 0;
        end
        seq_gap = w.seq != prev_seq + 16'd1;
        prev_seq = w.seq;
      end else if (!in_pkt) return;
      p = {16'h0, byte_pos};
      if (p == 0) hdr0 = w.b;
      else if (p == 1) begin
        typ = w.b[7:3];
        hdr1 = w.b;
        if (typ < TypeAp) begin
          kind = KIND_SINGLE;
          kill_nal();
          open_nal();
          emit(hdr0, 0, 0, 0);
          emit(w.b, 0, w.last, 0);
          if (w.last) nal_open = 0;
        end else if (typ == TypeAp) begin
          kind = KIND_AP;
          kill_nal();
          agg = AGG_LEN_HI;
        end else if (typ == TypeFu) kind = KIND_FU;
        else kind = KIND_NONE;
      end else if (kind == KIND_SINGLE) begin
        emit(w.b, 0, w.last, 0);
        if (w.last) nal_open = 0;
      end else if (kind == KIND_AP) begin
        if (!drop) agg_step(w.b, p);
      end else if (kind == KIND_FU) frag_step(w.b, p);
      if (w.last) begin
        if (kind == KIND_FU) begin
          if (p >= 2 && !drop && frag == FRAG_COLLECT && end_pend) begin
            if (held_ok) emit(held, 0, 1, 0);
            held_ok = 0;
            nal_open = 0;
            frag = FRAG_IDLE;
          end
        end else if (kind == KIND_SINGLE || kind == KIND_AP) begin
          if (nal_open) kill_nal();
          agg = AGG_LEN_HI;
        end
        in_pkt = 0;
      end
      if (byte_pos != 16'hffff) byte_pos++;
      if (n_new > 0) nal_q[$].run_last = 1;
    endfunction

    function void check_output(nal_word_t a);
      nal_word_t e;
      words_out++;
      if (a.abort) aborts_seen++;
      if (nal_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: byte %h abort %b", a.b, a.abort);
        return;
      end
      e = nal_q.pop_front();
      if (e != a) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp b=%h f=%b l=%b a=%b st=%h rl=%b %s",
                   e.b, e.first, e.last, e.abort, e.stamp, e.run_last,
                   $sformatf("got b=%h f=%b l=%b a=%b st=%h rl=%b",
                             a.b, a.first, a.last, a.abort, a.stamp, a.run_last));
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  rvnd_in_if  in_if ();
  rvnd_out_if out_if ();

  rtp_vvc_nal_depacketizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  nal_scoreboard sb;
  pay_word_t     pkt_q[$];
  logic          calm;
  int            idle_cnt;
  logic [15:0]   seq;
  logic [31:0]   stamp;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic idle_now();
    return !calm && $urandom_range(99) < 18;
  endfunction

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sb.note_input(pay_word_t'{in_if.payload_byte, in_if.byte_first, in_if.byte_last,
                                in_if.payload_len, in_if.seq_num, in_if.marker,
                                in_if.stamp_ms});
    end
    if (out_if.valid && out_if.ready) begin
      sb.check_output(nal_word_t'{out_if.out_byte, out_if.nal_first, out_if.nal_last,
                                  out_if.nal_abort, out_if.nal_stamp, out_if.run_last});
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    out_if.ready <= rst_ni && !idle_now();
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= StallLimit) begin
      $display("rtp_vvc_nal_depacketizer test failed");
      $finish;
    end
  end

  task automatic send_word(pay_word_t w);
    while (idle_now()) begin
      in_if.valid <= 0;
      @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.payload_byte <= w.b;
    in_if.byte_first <= w.first;
    in_if.byte_last <= w.last;
    in_if.payload_len <= w.len;
    in_if.seq_num <= w.seq;
    in_if.marker <= w.marker;
    in_if.stamp_ms <= w.stamp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Build one packet from the given bytes; len_field overrides the length when nonzero.
  task automatic send_packet(logic [7:0] bytes[$], logic mk, int gap, int len_field);
    pay_word_t w;
    seq = seq + 16'(gap);
    stamp = stamp + $urandom_range(40);
    for (int i = 0; i < bytes.size(); i++) begin
      w.b = bytes[i];
      w.first = i == 0;
      w.last = i == bytes.size() - 1;
      w.len = len_field != 0 ? 16'(len_field) : 16'(bytes.size());
      w.seq = w.first ? seq : 16'($urandom);
      w.marker = w.first ? mk : 1'($urandom);
      w.stamp = w.first ? stamp : $urandom;
      send_word(w);
    end
    seq = seq + 16'd1;
  endtask

  function automatic logic [7:0] hdr1_of(logic [4:0] typ);
    return {typ, 3'($urandom)};
  endfunction

  task automatic rand_bytes(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q = {q, 8'($urandom)};
  endtask

  task automatic single_pkt(int n, logic mk, int gap);
    logic [7:0] q[$];
    q = {8'($urandom), hdr1_of(5'($urandom_range(27)))};
    rand_bytes(q, n);
    send_packet(q, mk, gap, 0);
  endtask

  task automatic agg_pkt(int entries, logic bad);
    logic [7:0] q[$];
    int sz;
    q = {8'($urandom), hdr1_of(TypeAp)};
    for (int e = 0; e < entries; e++) begin
      sz = $urandom_range(1, 4);
      if (bad && e == entries - 1) sz = $urandom_range(1) ? 0 : 40;
      q = {q, 8'(sz >> 8), 8'(sz)};
      rand_bytes(q, sz > 8 ? 2 : sz);
    end
    if (bad || $urandom_range(3) == 0) rand_bytes(q, $urandom_range(1, 2));
    send_packet(q, 1'($urandom), 0, 0);
  endtask

  task automatic fu_pkt(logic s, logic e, int n, logic mk, int gap);
    logic [7:0] q[$];
    q = {8'($urandom), hdr1_of(TypeFu), {s, e, 1'($urandom), 5'($urandom)}};
    rand_bytes(q, n);
    send_packet(q, mk, gap, 0);
  endtask

  task automatic fu_nal(int parts, int gap_at);
    fu_pkt(1, 0, $urandom_range(0, 3), 0, 0);
    for (int i = 1; i < parts; i++)
      fu_pkt(0, i == parts - 1, $urandom_range(0, 3), 1'($urandom), i == gap_at ? 3 : 0);
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (sb.nal_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] q[$];
    sb = new();
    calm = 0;
    idle_cnt = 0;
    seq = 16'hfffd;
    stamp = 32'hffff_ffe0;
    rst_ni = 0;
    in_if.valid = 0;
    in_if.payload_byte = 0;
    in_if.byte_first = 0;
    in_if.byte_last = 0;
    in_if.payload_len = 0;
    in_if.seq_num = 0;
    in_if.marker = 0;
    in_if.stamp_ms = 0;
    out_if.ready = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: stray byte, short packets, extreme fields, each packet kind
    send_word(pay_word_t'{8'hff, 0, 1, 16'hffff, 16'hffff, 1, 32'hffffffff});
    q = {8'hff};
    send_packet(q, 1, 0, 16'hffff);
    q = {8'h00, 8'hf8};
    send_packet(q, 0, 0, 0);
    q = {8'hff, 8'h00, 8'hff};
    send_packet(q, 1, 0, 16'hffff);
    q = {8'h12, 8'hea, 8'hc5};
    send_packet(q, 1, 0, 0);
    q = {8'h34, 8'he9, 8'h85, 8'haa, 8'h55};
    send_packet(q, 0, 0, 0);
    q = {8'h01, 8'he8, 8'h00, 8'h01, 8'h7e, 8'h00, 8'h00};
    send_packet(q, 0, 0, 0);
    drain();
    calm = 1;
    fu_nal(3, 0);
    fu_nal(3, 2);
    fu_pkt(0, 1, 2, 0, 0);
    calm = 0;
    q = {8'h56, 8'he9};
    send_packet(q, 0, 0, 0);
    drain();

    for (int k = 0; k < 25; k++) begin
      case ($urandom_range(9))
        0, 1, 2: single_pkt($urandom_range(0, 4), 1'($urandom), $urandom_range(3) == 0);
        3, 4: agg_pkt($urandom_range(1, 3), $urandom_range(4) == 0);
        5, 6, 7: fu_nal($urandom_range(1, 4), $urandom_range(5));
        8: begin
          q.delete();
          rand_bytes(q, $urandom_range(1, 5));
          send_packet(q, 1'($urandom), 0, $urandom_range(1) ? 0 : $urandom_range(1, 65535));
        end
        default: begin
          // truncated packet: no last byte before the next first byte
          q.delete();
          q = {8'($urandom), hdr1_of($urandom_range(1) ? TypeFu : 5'($urandom_range(27))),
               8'h80 | 8'($urandom)};
          for (int i = 0; i < q.size(); i++)
            send_word(pay_word_t'{q[i], i == 0, 0, 16'd10, seq, 0, stamp});
          seq++;
        end
      endcase
      if (k == 12) begin
        drain();
        calm = 1;
      end
      if (k == 18) calm = 0;
    end
    drain();
    $display("covered %0d payload words, %0d NAL words out, %0d aborts",
             sb.words_in, sb.words_out, sb.aborts_seen);
    $display("single, aggregation and fragment packets with loss and truncation");
    if (sb.errors == 0 && sb.nal_q.size() == 0) begin
      $display("rtp_vvc_nal_depacketizer test passed");
    end else begin
      $display("rtp_vvc_nal_depacketizer test failed");
    end
    $finish;
  end

endmodule
